// ===== rtl/core/tdq_pkg.sv =====
// Shared types and codes for the timed delay queue.
// Used by tdq_cfg, tdq_ctrl and timed_delay_queue; depends on nothing.
package tdq_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned EntryW  = ValueW + TimeW;
  localparam int unsigned CapW    = 5;

  // Operation codes
  localparam logic [ModeW-1:0] MODE_SEND = 2'd0;
  localparam logic [ModeW-1:0] MODE_RECV = 2'd1;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_CLOSED    = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_READY = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd4;

  // Register indexes
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_CLOSED   = 1'b1;

  localparam logic [CapW-1:0] CAPACITY_RESET = 5'd16;

  // Configuration handed from the register file to the sequencer
  typedef struct packed {
    logic [CapW-1:0] capacity;
    logic            closed;
  } cfg_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value;
  } result_t;

endpackage

// ===== rtl/core/tdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module tdq_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tdq_cfg.sv =====
// APB-style register file for capacity and closed.
// Depends on tdq_pkg.
module tdq_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output tdq_pkg::cfg_t        cfg_o
);

  logic [tdq_pkg::CapW-1:0] capacity_q, capacity_d;
  logic                     closed_q, closed_d;
  logic                     wr_en;
  logic                     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Decode writes
  always_comb begin
    capacity_d = capacity_q;
    closed_d   = closed_q;
    if (wr_en) begin
      case (reg_sel)
        tdq_pkg::REG_CAPACITY: capacity_d = pwdata[tdq_pkg::CapW-1:0];
        tdq_pkg::REG_CLOSED:   closed_d   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= tdq_pkg::CAPACITY_RESET;
      closed_q   <= 1'b0;
    end else begin
      capacity_q <= capacity_d;
      closed_q   <= closed_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      tdq_pkg::REG_CAPACITY: prdata = {{(32 - tdq_pkg::CapW){1'b0}}, capacity_q};
      tdq_pkg::REG_CLOSED:   prdata = {31'd0, closed_q};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg_o.capacity = capacity_q;
  assign cfg_o.closed   = closed_q;

endmodule

// ===== rtl/core/tdq_ctrl.sv =====
// Sequencer of the delay queue: append on send, scan for the earliest due
// entry and shift later entries down on receive. Depends on tdq_pkg, tdq_ram.
module tdq_ctrl #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdq_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tdq_pkg::ModeW-1:0]     mode_i,
  input  logic [tdq_pkg::ValueW-1:0]    value_i,
  input  logic [tdq_pkg::TimeW-1:0]     delay_i,
  input  logic [tdq_pkg::TimeW-1:0]     now_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output tdq_pkg::result_t              res_o
);

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > tdq_pkg::CapW) ? CNT_W : tdq_pkg::CapW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEND  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             ptr_q, ptr_d;
  logic                         pend_q, pend_d;
  logic [AW-1:0]                pend_idx_q, pend_idx_d;
  logic                         found_q, found_d;
  logic [AW-1:0]                best_idx_q, best_idx_d;
  logic [tdq_pkg::TimeW-1:0]    best_dl_q, best_dl_d;
  logic [tdq_pkg::ValueW-1:0]   best_val_q, best_val_d;
  logic [tdq_pkg::ModeW-1:0]    mode_q, mode_d;
  logic [tdq_pkg::ValueW-1:0]   value_q, value_d;
  logic [tdq_pkg::TimeW-1:0]    delay_q, delay_d;
  logic [tdq_pkg::TimeW-1:0]    now_q, now_d;
  tdq_pkg::result_t             res_q, res_d;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [tdq_pkg::EntryW-1:0]   ram_wdata;
  logic                         ram_re;
  logic [tdq_pkg::EntryW-1:0]   ram_rdata;
  logic [tdq_pkg::TimeW-1:0]    rd_dl;
  logic                         rd_due;
  logic                         rd_better;
  logic [CMP_W-1:0]             cap_eff;
  logic                         full;
  logic [tdq_pkg::StatusW-1:0]  idle_status;

  tdq_ram #(
    .WIDTH (tdq_pkg::EntryW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Clamp capacity to one..depth and test for full
  always_comb begin
    cap_eff = CMP_W'(cfg_i.capacity);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end
    if (cap_eff > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end
  end
  assign full = CMP_W'(count_q) >= cap_eff;

  // Status when nothing is due
  always_comb begin
    if (count_q != '0) begin
      idle_status = tdq_pkg::ST_NOT_READY;
    end else if (cfg_i.closed) begin
      idle_status = tdq_pkg::ST_CLOSED;
    end else begin
      idle_status = tdq_pkg::ST_EMPTY;
    end
  end

  // Shared deadline compare on the entry just read
  assign rd_dl     = ram_rdata[tdq_pkg::EntryW-1:tdq_pkg::ValueW];
  assign rd_due    = rd_dl <= now_q;
  assign rd_better = !found_q || (rd_dl < best_dl_q);

  assign ram_re     = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (ptr_q < count_q);
  assign in_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    pend_d     = 1'b0;
    pend_idx_d = ptr_q[AW-1:0];
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_dl_d  = best_dl_q;
    best_val_d = best_val_q;
    mode_d     = mode_q;
    value_d    = value_q;
    delay_d    = delay_q;
    now_d      = now_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[AW-1:0];
    ram_wdata  = {now_q + delay_q, value_q};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          value_d = value_i;
          delay_d = delay_i;
          now_d   = now_i;
          ptr_d   = '0;
          found_d = 1'b0;
          state_d = (mode_i == tdq_pkg::MODE_SEND) ? S_SEND : S_SCAN;
        end
      end

      // Append at the tail unless closed or full
      S_SEND: begin
        res_d.value = '0;
        if (cfg_i.closed) begin
          res_d.status = tdq_pkg::ST_CLOSED;
        end else if (full) begin
          res_d.status = tdq_pkg::ST_FULL;
        end else begin
          ram_we       = 1'b1;
          count_d      = count_q + CNT_W'(1);
          res_d.status = tdq_pkg::ST_OK;
        end
        state_d = S_DONE;
      end

      // Read one entry a cycle, compare the one read last cycle
      S_SCAN: begin
        if (ram_re) begin
          ptr_d  = ptr_q + CNT_W'(1);
          pend_d = 1'b1;
        end
        if (pend_q && rd_due && rd_better) begin
          found_d    = 1'b1;
          best_idx_d = pend_idx_q;
          best_dl_d  = rd_dl;
          best_val_d = ram_rdata[tdq_pkg::ValueW-1:0];
        end
        if (!ram_re && !pend_q) begin
          res_d.value = '0;
          if (found_q) begin
            res_d.status = tdq_pkg::ST_OK;
            if (mode_q == tdq_pkg::MODE_RECV) begin
              res_d.value = best_val_q;
              ptr_d       = CNT_W'(best_idx_q) + CNT_W'(1);
              state_d     = S_SHIFT;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            res_d.status = idle_status;
            state_d      = S_DONE;
          end
        end
      end

      // Move each later entry down by one
      S_SHIFT: begin
        if (ram_re) begin
          ptr_d  = ptr_q + CNT_W'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!ram_re && !pend_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end

      // Hold the result until the output register takes it
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_dl_q  <= best_dl_d;
    best_val_q <= best_val_d;
    mode_q     <= mode_d;
    value_q    <= value_d;
    delay_q    <= delay_d;
    now_q      <= now_d;
    res_q      <= res_d;
  end

endmodule

// ===== rtl/core/timed_delay_queue.sv =====
// Timed delay queue: holds up to MAX_ENTRIES signed 32-bit items, each with a
// 64-bit deadline of now plus delay (wrapping). A send (tuser 0) appends an
// item or reports closed or full; a receive (tuser 1) removes the due item
// with the smallest deadline, earliest send first on ties; a poll (tuser 2 or
// 3) reports the same status without removing anything. Entries live in one
// RAM with a single read and a single write port, and the 64-bit deadline
// compares walk them one per cycle. A send is appended or refused in the
// send state; a poll or a receive scans every stored entry through the
// registered read port, and a successful receive then shifts each later
// entry down by one, so the walk is set by the one RAM read port. No item
// is accepted while one is in progress; the next one is taken only after
// the result has been handed to the output register. Configuration is at
// APB byte addresses 0 (capacity) and 4 (closed).
module timed_delay_queue #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // APB configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // Input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [159:0]  s_axis_tdata,   // value[31:0], delay[95:32], now_ns[159:96]
  input  logic [1:0]    s_axis_tuser,   // mode[1:0]
  // Result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,   // value_out[31:0]
  output logic [2:0]    m_axis_tuser    // status[2:0]
);

  tdq_pkg::cfg_t    cfg;
  tdq_pkg::result_t res;
  logic             res_valid;
  logic             res_take;
  logic             out_valid_q, out_valid_d;
  tdq_pkg::result_t out_q;

  tdq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tdq_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .value_i     (s_axis_tdata[31:0]),
    .delay_i     (s_axis_tdata[95:32]),
    .now_i       (s_axis_tdata[159:96]),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.status;

endmodule
